>>> rtl/core/lmqm_pkg.sv
// Package with the request codes, widths and queue entry type of the multi-queue manager.
package lmqm_pkg;

  localparam int PTR_W = 12;
  localparam int QID_W = 7;
  localparam int REQ_W = 2;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEAVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_JOIN  = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    ptr_t head;
    ptr_t tail;
  } qentry_t;

endpackage

>>> rtl/core/linked_multi_queue_manager.sv
// Top level of the linked-list multi-queue manager with its queue and link memories.
//
// Requests enter on in_valid/in_ready with req_type, queue_id, dest_queue and
// element_id. Each request gives exactly one result on out_valid/out_ready with
// status and popped_element. Add appends an element to a queue, leave pops the
// head of a queue, and join moves a whole queue onto the tail of another.
// Head and tail pointers live in a queue memory with two read ports, and the
// next links in a link memory. A request reads the queue memory in the cycle
// it is accepted, then modifies and writes back in the EXEC state, passes the
// WR2 state for a second write (add to a non-empty queue, join) or the LINK
// state for a link read (leave of a queue with more than one element), and
// loads the result in the DONE state. A new request is taken only once the
// last one has reached DONE; the single write port of each memory is why a
// second write needs its own state. After reset the block clears the queue
// memory one entry per cycle and holds in_ready low meanwhile.
// The result sits in an output register; while the receiver stalls, the block
// still accepts one more request and holds its result until the register frees.
module linked_multi_queue_manager #(
  parameter int NUM_QUEUES   = 128,
  parameter int NUM_ELEMENTS = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lmqm_pkg::REQ_W-1:0] req_type,
  input  logic [lmqm_pkg::QID_W-1:0] queue_id,
  input  logic [lmqm_pkg::QID_W-1:0] dest_queue,
  input  logic [lmqm_pkg::PTR_W-1:0] element_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       status,
  output logic [lmqm_pkg::PTR_W-1:0] popped_element
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int EW = $clog2(NUM_ELEMENTS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_LINK  = 3'd3;
  localparam logic [2:0] ST_WR2   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  lmqm_pkg::qentry_t qmem [NUM_QUEUES];
  lmqm_pkg::ptr_t    link_mem [NUM_ELEMENTS];

  logic [2:0] state, state_next;
  logic [QW-1:0] clr_cnt;

  logic [lmqm_pkg::REQ_W-1:0] r_type;
  logic [lmqm_pkg::QID_W-1:0] r_q, r_d;
  lmqm_pkg::ptr_t             r_e;

  logic           res_status, res_status_next;
  lmqm_pkg::ptr_t res_popped, res_popped_next;

  logic              w2_q_we, w2_q_we_next;
  logic [QW-1:0]     w2_q_addr, w2_q_addr_next;
  lmqm_pkg::qentry_t w2_q_data, w2_q_data_next;
  logic              w2_l_we, w2_l_we_next;
  logic [EW-1:0]     w2_l_addr, w2_l_addr_next;
  lmqm_pkg::ptr_t    w2_l_data, w2_l_data_next;

  logic              q_we;
  logic [QW-1:0]     q_waddr, q_raddr_a, q_raddr_b;
  lmqm_pkg::qentry_t q_wdata, qrd_a, qrd_b;
  logic              l_we;
  logic [EW-1:0]     l_waddr, l_raddr;
  lmqm_pkg::ptr_t    l_wdata, link_rd;

  logic          in_fire, out_free;
  logic          q_ok, d_ok, e_ok;
  logic [QW-1:0] qa_idx, qd_idx;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || ((state == ST_DONE) && out_free);
  assign in_fire  = in_valid && in_ready;

  assign qa_idx = QW'(r_q);
  assign qd_idx = QW'(r_d);
  assign q_ok   = int'(r_q) < NUM_QUEUES;
  assign d_ok   = (int'(r_d) < NUM_QUEUES) && (r_d != r_q);
  assign e_ok   = (r_e != '0) && (int'(r_e) < NUM_ELEMENTS);

  assign q_raddr_a = (state inside {ST_IDLE, ST_DONE}) ? QW'(queue_id) : qa_idx;
  assign q_raddr_b = (state inside {ST_IDLE, ST_DONE}) ? QW'(dest_queue) : qd_idx;
  assign l_raddr   = EW'(qrd_a.head);

  always_comb begin
    state_next      = state;
    q_we            = 1'b0;
    q_waddr         = qa_idx;
    q_wdata         = '0;
    l_we            = 1'b0;
    l_waddr         = EW'(r_e);
    l_wdata         = '0;
    res_status_next = res_status;
    res_popped_next = res_popped;
    w2_q_we_next    = w2_q_we;
    w2_q_addr_next  = w2_q_addr;
    w2_q_data_next  = w2_q_data;
    w2_l_we_next    = w2_l_we;
    w2_l_addr_next  = w2_l_addr;
    w2_l_data_next  = w2_l_data;
    case (state)
      ST_CLEAR: begin
        q_we    = 1'b1;
        q_waddr = clr_cnt;
        if (clr_cnt == QW'(NUM_QUEUES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_status_next = 1'b0;
        res_popped_next = '0;
        w2_q_we_next    = 1'b0;
        w2_l_we_next    = 1'b0;
        state_next      = ST_DONE;
        case (r_type)
          lmqm_pkg::REQ_ADD: begin
            if (q_ok && e_ok) begin
              l_we         = 1'b1;
              l_waddr      = EW'(r_e);
              l_wdata      = '0;
              q_we         = 1'b1;
              q_waddr      = qa_idx;
              q_wdata.head = (qrd_a.tail == '0) ? r_e : qrd_a.head;
              q_wdata.tail = r_e;
              if (qrd_a.tail != '0) begin
                w2_l_we_next   = 1'b1;
                w2_l_addr_next = EW'(qrd_a.tail);
                w2_l_data_next = r_e;
                state_next     = ST_WR2;
              end
            end
          end
          lmqm_pkg::REQ_LEAVE: begin
            if (q_ok) begin
              if (qrd_a.head == '0) begin
                res_status_next = 1'b1;
              end else begin
                res_popped_next = qrd_a.head;
                if (qrd_a.head == qrd_a.tail) begin
                  q_we    = 1'b1;
                  q_waddr = qa_idx;
                  q_wdata = '0;
                end else begin
                  state_next = ST_LINK;
                end
              end
            end
          end
          lmqm_pkg::REQ_JOIN: begin
            if (q_ok && d_ok) begin
              q_we    = 1'b1;
              q_waddr = qa_idx;
              q_wdata = '0;
              if (qrd_b.head != '0) begin
                l_we    = 1'b1;
                l_waddr = EW'(qrd_b.tail);
                l_wdata = qrd_a.head;
              end
              w2_q_we_next        = 1'b1;
              w2_q_addr_next      = qd_idx;
              w2_q_data_next.head = (qrd_b.head == '0) ? qrd_a.head : qrd_b.head;
              w2_q_data_next.tail = (qrd_a.tail != '0) ? qrd_a.tail : qrd_b.tail;
              state_next          = ST_WR2;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_LINK: begin
        q_we         = 1'b1;
        q_waddr      = qa_idx;
        q_wdata.head = link_rd;
        q_wdata.tail = qrd_a.tail;
        state_next   = ST_DONE;
      end
      ST_WR2: begin
        q_we       = w2_q_we;
        q_waddr    = w2_q_addr;
        q_wdata    = w2_q_data;
        l_we       = w2_l_we;
        l_waddr    = w2_l_addr;
        l_wdata    = w2_l_data;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = in_fire ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    qrd_a <= qmem[q_raddr_a];
    qrd_b <= qmem[q_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      link_mem[l_waddr] <= l_wdata;
    end
    link_rd <= link_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      r_type <= req_type;
      r_q    <= queue_id;
      r_d    <= dest_queue;
      r_e    <= element_id;
    end
    res_status <= res_status_next;
    res_popped <= res_popped_next;
    w2_q_we    <= w2_q_we_next;
    w2_q_addr  <= w2_q_addr_next;
    w2_q_data  <= w2_q_data_next;
    w2_l_we    <= w2_l_we_next;
    w2_l_addr  <= w2_l_addr_next;
    w2_l_data  <= w2_l_data_next;
    if ((state == ST_DONE) && out_free) begin
      status         <= res_status;
      popped_element <= res_popped;
    end
  end

  // An accepted request always starts its read-modify-write in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_EXEC)
    else $error("accepted request did not start execution");

  // A leave on an empty queue never reports an element.
  a_empty_no_elem: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> popped_element == '0)
    else $error("empty status with a popped element");

  // Element zero marks the end of a list and never gets a link written.
  a_link_nonzero: assert property (@(posedge clk) disable iff (rst)
    l_we |-> l_waddr != '0)
    else $error("link written for element zero");

endmodule
